[design/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the software timer table
// Slot record, scan control and head result types, action and event codes.
// ----------------------------------------------------------------------------
package stt_pkg;

    // table geometry
    localparam int NUM_SLOTS   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int TICK_W      = 32;
    localparam int ID_W        = 4;
    localparam int STEP_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CMP_W       = (STEP_W > ID_W) ? STEP_W : ID_W;

    // request codes
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // event codes
    localparam logic [1:0] EV_ADDED     = 2'd0;
    localparam logic [1:0] EV_FULL      = 2'd1;
    localparam logic [1:0] EV_CANCELLED = 2'd2;
    localparam logic [1:0] EV_EXPIRED   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // contents of one timer slot
    typedef struct packed {
        logic              valid;
        logic [TICK_W-1:0] expiry;
        logic [TICK_W-1:0] period;
        logic              one_shot;
    } t_slot;

    // request being scanned, as seen by the head
    typedef struct packed {
        logic [1:0]        action;
        logic [TICK_W-1:0] now_ticks;
        logic [TICK_W-1:0] delay_ticks;
        logic              one_shot;
        logic [ID_W-1:0]   slot_index;
        logic [STEP_W-1:0] step;
        logic              add_done;
        logic              cap_ok;
    } t_scan_ctl;

    // event raised by the head for the slot under it
    typedef struct packed {
        logic            hit;
        logic [1:0]      kind;
        logic [ID_W-1:0] slot_id;
    } t_head_res;

endpackage

[design/software_timer_table.sv]
// ----------------------------------------------------------------------------
// software_timer_table: fixed table of software timers
// Slots sit in a ring of cells that rotates once per request past one head
// unit, so every request visits the slots in ascending order.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------
//   in      | input     | i_in_valid / o_in_ready  | action, now, delay, shot,
//           |           |                          | slot index
//   out     | output    | o_out_valid / i_out_ready| event kind, slot id, last
//
// Each request is loaded, then the ring shifts every slot past the head in
// turn, then any final beat is sent.
// Output stalls freeze the ring; the input is taken only when idle.
// Reset clears slot live flags, control state and the output beat at once.
// ----------------------------------------------------------------------------
module software_timer_table
    import stt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [TICK_W-1:0] i_now_ticks,
    input  logic [TICK_W-1:0] i_delay_ticks,
    input  logic              i_one_shot,
    input  logic [ID_W-1:0]   i_slot_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_event_kind,
    output logic [ID_W-1:0]   o_slot_id,
    output logic              o_last
);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_action, n_action;
    logic [TICK_W-1:0] r_now, n_now;
    logic [TICK_W-1:0] r_delay, n_delay;
    logic              r_once, n_once;
    logic [ID_W-1:0]   r_idx, n_idx;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_pend_valid, n_pend_valid;
    logic [1:0]        r_pend_kind, n_pend_kind;
    logic [ID_W-1:0]   r_pend_slot, n_pend_slot;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_kind, n_out_kind;
    logic [ID_W-1:0]   r_out_slot, n_out_slot;
    logic              r_out_last, n_out_last;

    logic      w_out_free;
    logic      w_shift;
    t_scan_ctl w_ctl;
    t_slot     w_head_new;
    t_head_res w_res;
    t_slot     w_cell_q [NUM_SLOTS];

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_shift    = (r_state == ST_SCAN) && w_out_free;

    // request context for the head
    assign w_ctl = '{action: r_action, now_ticks: r_now, delay_ticks: r_delay,
                     one_shot: r_once, slot_index: r_idx, step: r_step,
                     add_done: r_done,
                     cap_ok: (r_count < CNT_W'(MAX_RESULTS))};

    stt_head u_head (
        .i_ctl  (w_ctl),
        .i_slot (w_cell_q[0]),
        .o_slot (w_head_new),
        .o_res  (w_res)
    );

    // ring of slot cells, the head writes back into the tail
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        t_slot w_in;
        if (g == NUM_SLOTS - 1) begin : g_tail
            assign w_in = w_head_new;
        end else begin : g_body
            assign w_in = w_cell_q[g+1];
        end
        stt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_slot  (w_in),
            .o_slot  (w_cell_q[g])
        );
    end

    // sequencer and result staging
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_action     = r_action;
        n_now        = r_now;
        n_delay      = r_delay;
        n_once       = r_once;
        n_idx        = r_idx;
        n_done       = r_done;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_action     = i_action;
                    n_now        = i_now_ticks;
                    n_delay      = i_delay_ticks;
                    n_once       = i_one_shot;
                    n_idx        = i_slot_index;
                    n_step       = '0;
                    n_done       = 1'b0;
                    n_count      = '0;
                    // an add answers full unless a free slot turns up
                    n_pend_valid = (i_action == ACT_ADD);
                    n_pend_kind  = EV_FULL;
                    n_pend_slot  = '0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_out_free) begin
                    if (w_res.hit) begin
                        // earlier expiry goes out, not the final beat
                        if (r_action == ACT_TICK && r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_pend_kind;
                            n_out_slot  = r_pend_slot;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_kind  = w_res.kind;
                        n_pend_slot  = w_res.slot_id;
                        if (r_action == ACT_ADD) begin
                            n_done = 1'b1;
                        end
                        if (r_action == ACT_TICK) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    if (r_step == STEP_W'(NUM_SLOTS - 1)) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = r_pend_kind;
                        n_out_slot  = r_pend_slot;
                        n_out_last  = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_action    <= n_action;
        r_now       <= n_now;
        r_delay     <= n_delay;
        r_once      <= n_once;
        r_idx       <= n_idx;
        r_done      <= n_done;
        r_count     <= n_count;
        r_pend_kind <= n_pend_kind;
        r_pend_slot <= n_pend_slot;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_last  <= n_out_last;
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_slot_id    = r_out_slot;
    assign o_last       = r_out_last;

endmodule

[design/stt_cell.sv]
// ----------------------------------------------------------------------------
// stt_cell: one timer slot in the rotating chain
// Holds a slot record and loads its neighbor's record on every shift.
// ----------------------------------------------------------------------------
module stt_cell
    import stt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_slot,
    output t_slot o_slot
);

    logic              r_valid;
    logic [TICK_W-1:0] r_expiry;
    logic [TICK_W-1:0] r_period;
    logic              r_one_shot;

    // live flag, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_slot.valid;
        end
    end

    // timer payload
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_expiry   <= i_slot.expiry;
            r_period   <= i_slot.period;
            r_one_shot <= i_slot.one_shot;
        end
    end

    assign o_slot = '{valid: r_valid, expiry: r_expiry, period: r_period,
                      one_shot: r_one_shot};

endmodule

[design/stt_head.sv]
// ----------------------------------------------------------------------------
// stt_head: slot update at the head of the chain
// Applies the current request to the slot passing the head and flags events.
// ----------------------------------------------------------------------------
module stt_head
    import stt_pkg::*;
(
    input  t_scan_ctl i_ctl,
    input  t_slot     i_slot,
    output t_slot     o_slot,
    output t_head_res o_res
);

    logic w_idx_match;
    logic w_due;

    assign w_idx_match = (CMP_W'(i_ctl.step) == CMP_W'(i_ctl.slot_index));
    assign w_due       = i_slot.valid && (i_slot.expiry <= i_ctl.now_ticks);

    // per-request slot update
    always_comb begin
        o_slot        = i_slot;
        o_res.hit     = 1'b0;
        o_res.kind    = EV_ADDED;
        o_res.slot_id = ID_W'(i_ctl.step);
        case (i_ctl.action)
            ACT_ADD: begin
                // first free slot in scan order is claimed
                if (!i_ctl.add_done && !i_slot.valid) begin
                    o_slot.valid    = 1'b1;
                    o_slot.expiry   = i_ctl.now_ticks + i_ctl.delay_ticks;
                    o_slot.period   = i_ctl.delay_ticks;
                    o_slot.one_shot = i_ctl.one_shot;
                    o_res.hit       = 1'b1;
                    o_res.kind      = EV_ADDED;
                end
            end
            ACT_CANCEL: begin
                if (w_idx_match) begin
                    o_slot.valid = 1'b0;
                    o_res.hit    = 1'b1;
                    o_res.kind   = EV_CANCELLED;
                end
            end
            ACT_TICK: begin
                // expiry, then free or reload
                if (w_due && i_ctl.cap_ok) begin
                    o_res.hit  = 1'b1;
                    o_res.kind = EV_EXPIRED;
                    if (i_slot.one_shot) begin
                        o_slot.valid = 1'b0;
                    end else begin
                        o_slot.expiry = i_slot.expiry + i_slot.period;
                    end
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

[design/stt_checker.sv]
// ----------------------------------------------------------------------------
// stt_checker: port-level checks for the software timer table
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [1:0]        i_action,
    input logic [TICK_W-1:0] i_now_ticks,
    input logic [TICK_W-1:0] i_delay_ticks,
    input logic              i_one_shot,
    input logic [ID_W-1:0]   i_slot_index,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        o_event_kind,
    input logic [ID_W-1:0]   o_slot_id,
    input logic              o_last
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_event_kind) && $stable(o_slot_id)
            && $stable(o_last))
        else $error("output beat changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still ready right after a beat was taken");

    // reset leaves no output beat
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat present after reset");

    // table full answers with slot zero as the only beat
    a_full_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == EV_FULL |-> o_slot_id == '0 && o_last)
        else $error("malformed table full beat");

    // add and cancel answers are single beats
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_ADDED || o_event_kind == EV_CANCELLED)
            |-> o_last)
        else $error("add or cancel answer not marked last");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the software timer table
// Drives add, cancel and tick requests through the valid/ready request
// channel, predicts every event beat from a behavioral copy of the slot
// table, and compares each beat on the event channel in order. Directed
// tests cover extremes, cancels, ignored requests, a full table and a burst
// of expiries; random traffic follows a rising tick count under three
// idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
    import stt_pkg::*;

    // unused request code, ignored by the block
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int RUN_LIMIT    = 8 * 400000;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] slot;
        logic            last;
    } t_timer_event;

    logic              i_clk;
    logic              i_rst_n;
    logic              req_valid;
    logic              req_ready;
    logic [1:0]        req_action;
    logic [TICK_W-1:0] req_now;
    logic [TICK_W-1:0] req_delay;
    logic              req_one_shot;
    logic [ID_W-1:0]   req_slot;
    logic              evt_valid;
    logic              evt_ready;
    logic [1:0]        evt_kind;
    logic [ID_W-1:0]   evt_slot;
    logic              evt_last;

    // behavioral copy of the slot table
    logic              tbl_live   [NUM_SLOTS];
    logic [TICK_W-1:0] tbl_due    [NUM_SLOTS];
    logic [TICK_W-1:0] tbl_period [NUM_SLOTS];
    logic              tbl_once   [NUM_SLOTS];

    t_timer_event      pending_events[$];

    int                send_idle_pct;
    int                recv_idle_pct;
    logic [TICK_W-1:0] tick_base;
    int                error_count;
    int                n_add;
    int                n_cancel;
    int                n_tick;
    int                n_ignored;
    int                beats_checked;
    int                expiries_seen;

    software_timer_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (req_valid),
        .o_in_ready    (req_ready),
        .i_action      (req_action),
        .i_now_ticks   (req_now),
        .i_delay_ticks (req_delay),
        .i_one_shot    (req_one_shot),
        .i_slot_index  (req_slot),
        .o_out_valid   (evt_valid),
        .i_out_ready   (evt_ready),
        .o_event_kind  (evt_kind),
        .o_slot_id     (evt_slot),
        .o_last        (evt_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // event table update and expected beats for one accepted request
    task automatic predict_timer_events(input logic [1:0] act, input logic [TICK_W-1:0] now,
                                        input logic [TICK_W-1:0] delay, input logic shot,
                                        input logic [ID_W-1:0] idx);
        t_timer_event batch[$];
        t_timer_event ev;
        int free_slot;
        free_slot = -1;
        ev.last = 1'b0;
        case (act)
            ACT_ADD: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!tbl_live[i] && free_slot < 0) free_slot = i;
                end
                if (free_slot >= 0) begin
                    tbl_live[free_slot]   = 1'b1;
                    tbl_due[free_slot]    = now + delay;
                    tbl_period[free_slot] = delay;
                    tbl_once[free_slot]   = shot;
                    ev.kind = EV_ADDED;
                    ev.slot = free_slot[ID_W-1:0];
                end else begin
                    ev.kind = EV_FULL;
                    ev.slot = '0;
                end
                batch.push_back(ev);
            end
            ACT_CANCEL: begin
                if (int'(idx) < NUM_SLOTS) begin
                    tbl_live[idx] = 1'b0;
                    ev.kind = EV_CANCELLED;
                    ev.slot = idx;
                    batch.push_back(ev);
                end
            end
            ACT_TICK: begin
                for (int i = 0; i < NUM_SLOTS && batch.size() < MAX_RESULTS; i++) begin
                    if (tbl_live[i] && tbl_due[i] <= now) begin
                        ev.kind = EV_EXPIRED;
                        ev.slot = i[ID_W-1:0];
                        batch.push_back(ev);
                        if (tbl_once[i]) tbl_live[i] = 1'b0;
                        else tbl_due[i] = tbl_due[i] + tbl_period[i];
                    end
                end
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) pending_events.push_back(batch[k]);
    endtask

    // one request beat, with random idle cycles ahead of it
    task automatic send_request(input logic [1:0] act, input logic [TICK_W-1:0] now,
                                input logic [TICK_W-1:0] delay, input logic shot,
                                input logic [ID_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid = 1'b0;
            @(negedge i_clk);
        end
        req_valid    = 1'b1;
        req_action   = act;
        req_now      = now;
        req_delay    = delay;
        req_one_shot = shot;
        req_slot     = idx;
        do begin
            @(posedge i_clk);
        end while (!req_ready);
        predict_timer_events(act, now, delay, shot, idx);
        case (act)
            ACT_ADD:    n_add++;
            ACT_CANCEL: n_cancel++;
            ACT_TICK:   n_tick++;
            default:    n_ignored++;
        endcase
    endtask

    // hold the request channel until every expected beat is back
    task automatic wait_for_drain();
        @(negedge i_clk);
        req_valid = 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
    endtask

    // zero and all-ones times, wrapped expiry sums, zero delay
    task automatic test_extreme_times();
        send_request(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 4'h0);
        send_request(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 4'hF);
        send_request(ACT_TICK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 4'hF);
        send_request(ACT_TICK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 4'h0);
        send_request(ACT_TICK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 4'h0);
    endtask

    // cancel of a free slot and of a live one
    task automatic test_cancel();
        send_request(ACT_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'hF);
        send_request(ACT_CANCEL, 32'h0000_0000, 32'h0000_0000, 1'b0, 4'h1);
    endtask

    // unused action and a tick with nothing due give no beat
    task automatic test_ignored_requests();
        send_request(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'hF);
        send_request(ACT_TICK, 32'd1000, 32'd0, 1'b0, 4'h0);
    endtask

    // fill every slot, then one add too many
    task automatic test_table_full();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_request(ACT_ADD, 32'd100, 32'(i * 3), i[0], 4'h0);
        end
        send_request(ACT_ADD, 32'd100, 32'd5, 1'b0, 4'h0);
    endtask

    // every slot due at once, then periodic slots again
    task automatic test_burst_expiry();
        send_request(ACT_TICK, 32'd200, 32'd0, 1'b0, 4'h0);
        send_request(ACT_TICK, 32'd200, 32'd0, 1'b0, 4'h0);
        tick_base = 32'd200;
    endtask

    // mostly well-formed traffic on a rising tick count, plus noise
    task automatic test_random_traffic(input int n_requests);
        int sent;
        int roll;
        logic [1:0]        act;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] delay;
        logic              shot;
        logic [ID_W-1:0]   idx;
        sent = 0;
        while (sent < n_requests) begin
            roll  = $urandom_range(0, 99);
            now   = $urandom();
            delay = $urandom();
            shot  = 1'($urandom_range(0, 1));
            idx   = ID_W'($urandom_range(0, NUM_SLOTS - 1));
            if (roll < 35) begin
                act = ACT_ADD;
                now = tick_base;
                if ($urandom_range(0, 9) != 0) delay = $urandom_range(0, 60);
            end else if (roll < 55) begin
                act = ACT_CANCEL;
            end else if (roll < 92) begin
                act = ACT_TICK;
                tick_base = tick_base + $urandom_range(0, 25);
                now = tick_base;
            end else if (roll < 96) begin
                // tick at an arbitrary time
                act = ACT_TICK;
            end else begin
                act = ACT_NONE;
            end
            send_request(act, now, delay, shot, idx);
            if (act != ACT_NONE) sent++;
            if ($urandom_range(0, 49) == 0) wait_for_drain();
        end
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        evt_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare each event beat with the oldest expectation
    always @(posedge i_clk) begin
        t_timer_event exp_ev;
        if (i_rst_n && evt_valid && evt_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected beat: kind %0d slot %0d last %0b",
                       evt_kind, evt_slot, evt_last);
                error_count++;
            end else begin
                exp_ev = pending_events.pop_front();
                beats_checked++;
                if (exp_ev.kind == EV_EXPIRED) expiries_seen++;
                if (evt_kind !== exp_ev.kind) begin
                    $error("event_kind: expected %0d, actual %0d", exp_ev.kind, evt_kind);
                    error_count++;
                end
                if (evt_slot !== exp_ev.slot) begin
                    $error("slot_id: expected %0d, actual %0d", exp_ev.slot, evt_slot);
                    error_count++;
                end
                if (evt_last !== exp_ev.last) begin
                    $error("last: expected %0b, actual %0b", exp_ev.last, evt_last);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n       = 1'b0;
        req_valid     = 1'b0;
        req_action    = ACT_ADD;
        req_now       = '0;
        req_delay     = '0;
        req_one_shot  = 1'b0;
        req_slot      = '0;
        evt_ready     = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 80;
        tick_base     = '0;
        error_count   = 0;
        n_add         = 0;
        n_cancel      = 0;
        n_tick        = 0;
        n_ignored     = 0;
        beats_checked = 0;
        expiries_seen = 0;
        foreach (tbl_live[i]) tbl_live[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extreme_times();
        test_cancel();
        test_ignored_requests();
        test_table_full();
        test_burst_expiry();
        test_random_traffic(110);

        wait_for_drain();
        send_idle_pct = 80;
        recv_idle_pct = 18;
        test_random_traffic(110);

        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(110);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run: %0d adds, %0d cancels, %0d ticks, %0d ignored requests",
                 n_add, n_cancel, n_tick, n_ignored);
        $display("run: %0d event beats compared, %0d of them expiries",
                 beats_checked, expiries_seen);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
